@@ design/pdsv_pkg.sv @@
// ----------------------------------------------------------------------------
// pdsv_pkg
// Shared types and constants for the point density splat volume unit.
// ----------------------------------------------------------------------------
package pdsv_pkg;

  // Default geometry
  localparam int GRID_X_DEF    = 32;
  localparam int GRID_Y_DEF    = 32;
  localparam int GRID_Z_DEF    = 32;
  localparam int FRAC_BITS_DEF = 8;

  // Field widths
  localparam int CRD_W  = 13;  // point coordinate, unsigned fixed point
  localparam int RDI_W  = 5;   // read index
  localparam int RAD_W  = 10;  // splat radius
  localparam int GAIN_W = 24;  // splat gain
  localparam int VAL_W  = 32;  // voxel word
  localparam int CNT_W  = 10;  // updated voxel count
  localparam int DX_W   = 11;  // |offset| never exceeds the radius
  localparam int D2_W   = 22;  // sum of three squared offsets

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 1'b1;
  localparam int CFG_DATA_W = GAIN_W;

  // Reset values of the registers
  localparam logic [RAD_W-1:0]  RADIUS_RST = 10'd384;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 24'd250000;

  // Request codes
  localparam logic REQ_SPLAT = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [CRD_W-1:0] point_x;
    logic [CRD_W-1:0] point_y;
    logic [CRD_W-1:0] point_z;
    logic [RDI_W-1:0] read_x;
    logic [RDI_W-1:0] read_y;
    logic [RDI_W-1:0] read_z;
  } pdsv_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] updated_count;
    logic             clipped;
    logic             saturated;
  } pdsv_out_t;

endpackage

@@ design/pdsv_ram.sv @@
// ----------------------------------------------------------------------------
// pdsv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pdsv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/point_density_splat_volume_unit.sv @@
// ----------------------------------------------------------------------------
// point_density_splat_volume_unit
// Accumulates inverse-square weighted point splats into a voxel volume and
// reads single voxels back.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | start, busy, in_data           | beat when start && !busy
//  result  | out_valid, out_data            | one-cycle strobe, no stall
//  config  | cfg_we, cfg_index, cfg_data    | write when cfg_we, no wait
//
//  After reset the voxel RAM is cleared, one word a cycle, for all
//  GRID_X*GRID_Y*GRID_Z words; busy is high meanwhile. A read passes S_RD_WAIT
//  (in-grid index only) and S_DONE before its strobe. A splat runs S_VOX, S_SQ
//  per axis, S_DIV_INI, the 32-step shared restoring divider in S_DIV (skipped
//  on saturation), S_RMW and S_ADV per in-grid voxel, S_VOX and S_ADV per clipped
//  voxel. Results cannot be stalled; the strobe comes the cycle busy drops.
// ----------------------------------------------------------------------------
module point_density_splat_volume_unit #(
  parameter int GRID_X    = pdsv_pkg::GRID_X_DEF,
  parameter int GRID_Y    = pdsv_pkg::GRID_Y_DEF,
  parameter int GRID_Z    = pdsv_pkg::GRID_Z_DEF,
  parameter int FRAC_BITS = pdsv_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  pdsv_pkg::pdsv_in_t                 in_data,
  output logic                               out_valid,
  output pdsv_pkg::pdsv_out_t                out_data,
  input  logic                               cfg_we,
  input  logic [pdsv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdsv_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int DEPTH  = GRID_X * GRID_Y * GRID_Z;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IW     = (16 - FRAC_BITS > 10) ? 16 - FRAC_BITS : 10;
  localparam int SW     = pdsv_pkg::CRD_W + 2;
  localparam int EW     = IW + FRAC_BITS + 1;
  localparam int NUM_W  = pdsv_pkg::GAIN_W + 2 * FRAC_BITS;
  localparam int VW     = pdsv_pkg::VAL_W;
  localparam int STEP_W = $clog2(VW);

  // sequencer states
  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_RD_WAIT = 4'd2;
  localparam logic [3:0] S_VOX     = 4'd3;
  localparam logic [3:0] S_SQ      = 4'd4;
  localparam logic [3:0] S_DIV_INI = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_RMW     = 4'd7;
  localparam logic [3:0] S_ADV     = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  localparam logic signed [IW-1:0] GX_S = IW'(GRID_X);
  localparam logic signed [IW-1:0] GY_S = IW'(GRID_Y);
  localparam logic signed [IW-1:0] GZ_S = IW'(GRID_Z);
  localparam logic [VW-1:0] MAX_VAL = '1;

  logic [3:0]                     state_r, state_nxt;
  logic [pdsv_pkg::RAD_W-1:0]     radius_r;
  logic [pdsv_pkg::GAIN_W-1:0]    gain_r;
  logic [ADDR_W-1:0]              clr_addr_r;
  logic signed [IW-1:0]           i_r, j_r, k_r;
  logic signed [IW-1:0]           xh_r, yl_r, yh_r, zl_r, zh_r;
  logic [pdsv_pkg::CRD_W-1:0]     cx_r, cy_r, cz_r;
  logic signed [pdsv_pkg::DX_W-1:0] dx_r, dy_r, dz_r;
  logic [1:0]                     ph_r;
  logic [pdsv_pkg::D2_W-1:0]      d2_r;
  logic [pdsv_pkg::D2_W-1:0]      rem_r;
  logic [VW-1:0]                  numlo_r, q_r;
  logic [STEP_W-1:0]              step_r;
  logic [ADDR_W-1:0]              addr_r;
  logic [VW-1:0]                  rv_r;
  logic [pdsv_pkg::CNT_W-1:0]     cnt_r;
  logic                           clip_r, sat_r;
  logic                           out_valid_r;
  pdsv_pkg::pdsv_out_t            out_data_r;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= pdsv_pkg::RADIUS_RST;
      gain_r   <= pdsv_pkg::GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pdsv_pkg::REG_RADIUS: radius_r <= cfg_data[pdsv_pkg::RAD_W-1:0];
        pdsv_pkg::REG_GAIN:   gain_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------- per-axis box ranges
  logic signed [SW-1:0] rs;
  logic signed [SW-1:0] xm, xp, ym, yp, zm, zp;
  logic signed [IW-1:0] xl_c, xh_c, yl_c, yh_c, zl_c, zh_c;
  logic                 box_empty;

  always_comb begin
    rs   = SW'($signed({1'b0, radius_r}));
    xm   = SW'($signed({1'b0, in_data.point_x})) - rs;
    xp   = SW'($signed({1'b0, in_data.point_x})) + rs;
    ym   = SW'($signed({1'b0, in_data.point_y})) - rs;
    yp   = SW'($signed({1'b0, in_data.point_y})) + rs;
    zm   = SW'($signed({1'b0, in_data.point_z})) - rs;
    zp   = SW'($signed({1'b0, in_data.point_z})) + rs;
    xl_c = IW'(xm >>> FRAC_BITS) + IW'(1);
    xh_c = IW'(xp >>> FRAC_BITS);
    yl_c = IW'(ym >>> FRAC_BITS) + IW'(1);
    yh_c = IW'(yp >>> FRAC_BITS);
    zl_c = IW'(zm >>> FRAC_BITS) + IW'(1);
    zh_c = IW'(zp >>> FRAC_BITS);
    box_empty = (xl_c > xh_c) || (yl_c > yh_c) || (zl_c > zh_c);
  end

  // ------------------------------------------------- read request address
  logic              rd_in_grid;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    rd_in_grid = (32'(in_data.read_x) < 32'(GRID_X)) &&
                 (32'(in_data.read_y) < 32'(GRID_Y)) &&
                 (32'(in_data.read_z) < 32'(GRID_Z));
    rd_addr = (ADDR_W'(in_data.read_x) * ADDR_W'(GRID_Y) + ADDR_W'(in_data.read_y))
              * ADDR_W'(GRID_Z) + ADDR_W'(in_data.read_z);
  end

  // ------------------------------------------------ current voxel offsets
  logic                     vox_out;
  logic signed [EW-1:0]     dx_w, dy_w, dz_w;
  logic [ADDR_W-1:0]        vox_addr;

  always_comb begin
    vox_out = (i_r < 0) || (i_r >= GX_S) || (j_r < 0) || (j_r >= GY_S) ||
              (k_r < 0) || (k_r >= GZ_S);
    dx_w = EW'($signed({1'b0, cx_r})) - (EW'(i_r) <<< FRAC_BITS);
    dy_w = EW'($signed({1'b0, cy_r})) - (EW'(j_r) <<< FRAC_BITS);
    dz_w = EW'($signed({1'b0, cz_r})) - (EW'(k_r) <<< FRAC_BITS);
    vox_addr = (ADDR_W'(i_r) * ADDR_W'(GRID_Y) + ADDR_W'(j_r)) * ADDR_W'(GRID_Z)
               + ADDR_W'(k_r);
  end

  // ----------------------------------------------- shared squaring unit
  logic signed [pdsv_pkg::DX_W-1:0]   mul_a;
  logic signed [2*pdsv_pkg::DX_W-1:0] sq;

  always_comb begin
    case (ph_r)
      2'd0:    mul_a = dx_r;
      2'd1:    mul_a = dy_r;
      default: mul_a = dz_r;
    endcase
    sq = mul_a * mul_a;
  end

  // -------------------------------------------- divider setup and step
  logic [NUM_W:0]               num_w;
  logic                         div_sat;
  logic [pdsv_pkg::D2_W:0]      trial;
  logic                         qbit;

  always_comb begin
    num_w   = {1'b0, gain_r, {(2 * FRAC_BITS){1'b0}}};
    div_sat = 32'(num_w[NUM_W:VW]) >= 32'(d2_r);
    trial   = {rem_r, numlo_r[VW-1]};
    qbit    = trial >= {1'b0, d2_r};
  end

  // ---------------------------------------------------- accumulate adder
  logic [VW-1:0] ram_rdata;
  logic [VW:0]   sum_w;

  assign sum_w = {1'b0, ram_rdata} + {1'b0, q_r};

  // ------------------------------------------------------- RAM controls
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VW-1:0]     ram_wdata;
  logic              accept;

  assign accept = start && (state_r == S_IDLE);

  always_comb begin
    ram_we    = (state_r == S_CLEAR) || (state_r == S_RMW);
    ram_waddr = (state_r == S_CLEAR) ? clr_addr_r : addr_r;
    ram_wdata = (state_r == S_CLEAR) ? '0 : (sum_w[VW] ? MAX_VAL : sum_w[VW-1:0]);
    ram_re    = (accept && in_data.req_type == pdsv_pkg::REQ_READ) ||
                (state_r == S_DIV_INI);
    ram_raddr = (state_r == S_IDLE) ? rd_addr : addr_r;
  end

  pdsv_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ------------------------------------------------------ next state
  logic last_i, last_j, last_k;

  assign last_k = (k_r == zh_r);
  assign last_j = (j_r == yh_r);
  assign last_i = (i_r == xh_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:   if (clr_addr_r == ADDR_W'(DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (accept) begin
          if (in_data.req_type == pdsv_pkg::REQ_READ) begin
            state_nxt = rd_in_grid ? S_RD_WAIT : S_DONE;
          end else begin
            state_nxt = box_empty ? S_DONE : S_VOX;
          end
        end
      end
      S_RD_WAIT: state_nxt = S_DONE;
      S_VOX:     state_nxt = vox_out ? S_ADV : S_SQ;
      S_SQ:      if (ph_r == 2'd2) state_nxt = S_DIV_INI;
      S_DIV_INI: state_nxt = div_sat ? S_RMW : S_DIV;
      S_DIV:     if (step_r == STEP_W'(VW - 1)) state_nxt = S_RMW;
      S_RMW:     state_nxt = S_ADV;
      S_ADV:     state_nxt = (last_i && last_j && last_k) ? S_DONE : S_VOX;
      S_DONE:    state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  // ------------------------------------------------------ datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          rv_r   <= '0;
          cnt_r  <= '0;
          clip_r <= (in_data.req_type == pdsv_pkg::REQ_READ) && !rd_in_grid;
          sat_r  <= 1'b0;
          cx_r   <= in_data.point_x;
          cy_r   <= in_data.point_y;
          cz_r   <= in_data.point_z;
          i_r    <= xl_c;
          j_r    <= yl_c;
          k_r    <= zl_c;
          xh_r   <= xh_c;
          yl_r   <= yl_c;
          yh_r   <= yh_c;
          zl_r   <= zl_c;
          zh_r   <= zh_c;
        end
      end
      S_RD_WAIT: rv_r <= ram_rdata;
      S_VOX: begin
        if (vox_out) begin
          clip_r <= 1'b1;
        end
        dx_r   <= pdsv_pkg::DX_W'(dx_w);
        dy_r   <= pdsv_pkg::DX_W'(dy_w);
        dz_r   <= pdsv_pkg::DX_W'(dz_w);
        addr_r <= vox_addr;
        ph_r   <= 2'd0;
      end
      S_SQ: begin
        // d2 accumulates one squared offset a cycle
        d2_r <= ((ph_r == 2'd0) ? '0 : d2_r) + pdsv_pkg::D2_W'(sq);
        ph_r <= ph_r + 2'd1;
      end
      S_DIV_INI: begin
        // quotient above 32 bits (or zero distance) saturates
        if (div_sat) begin
          q_r   <= MAX_VAL;
          sat_r <= 1'b1;
        end
        rem_r   <= pdsv_pkg::D2_W'(num_w[NUM_W:VW]);
        numlo_r <= num_w[VW-1:0];
        step_r  <= '0;
      end
      S_DIV: begin
        // one restoring step per cycle
        rem_r   <= qbit ? pdsv_pkg::D2_W'(trial - {1'b0, d2_r})
                        : pdsv_pkg::D2_W'(trial);
        q_r     <= {q_r[VW-2:0], qbit};
        numlo_r <= {numlo_r[VW-2:0], 1'b0};
        step_r  <= step_r + STEP_W'(1);
      end
      S_RMW: begin
        if (sum_w[VW]) begin
          sat_r <= 1'b1;
        end
        cnt_r <= cnt_r + pdsv_pkg::CNT_W'(1);
      end
      S_ADV: begin
        // z innermost, then y, then x
        if (!last_k) begin
          k_r <= k_r + IW'(1);
        end else begin
          k_r <= zl_r;
          if (!last_j) begin
            j_r <= j_r + IW'(1);
          end else begin
            j_r <= yl_r;
            i_r <= i_r + IW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------ result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_data_r.read_value    <= rv_r;
      out_data_r.updated_count <= cnt_r;
      out_data_r.clipped       <= clip_r;
      out_data_r.saturated     <= sat_r;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ design/pdsv_check.sv @@
// ----------------------------------------------------------------------------
// pdsv_check
// Port-level checks for the point density splat volume unit.
// ----------------------------------------------------------------------------
module pdsv_check (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input pdsv_pkg::pdsv_out_t out_data
);

  // an accepted beat keeps the unit busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  // results are single-cycle strobes
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result shows while the unit is idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // no result without work in flight
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !out_valid)
    else $error("result without an accepted beat");

  // read data and splat counts never mix
  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.read_value != '0) |->
      (out_data.updated_count == '0 && !out_data.saturated))
    else $error("read result carries splat fields");

endmodule

bind point_density_splat_volume_unit pdsv_check u_pdsv_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for point_density_splat_volume_unit. Splat and read commands are
// sent while busy is low; a local copy of the voxel volume predicts each
// result and every out_valid beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NGX = pdsv_pkg::GRID_X_DEF;
  localparam int NGY = pdsv_pkg::GRID_Y_DEF;
  localparam int NGZ = pdsv_pkg::GRID_Z_DEF;
  localparam int FB  = pdsv_pkg::FRAC_BITS_DEF;
  localparam longint SAT32 = 64'hFFFF_FFFF;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  pdsv_pkg::pdsv_in_t              in_data = '0;
  logic                            out_valid;
  pdsv_pkg::pdsv_out_t             out_data;
  logic                            cfg_we = 1'b0;
  logic [pdsv_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pdsv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: the volume and the two registers
  logic [pdsv_pkg::VAL_W-1:0]  vol_model [NGX*NGY*NGZ];
  logic [pdsv_pkg::RAD_W-1:0]  mdl_radius;
  logic [pdsv_pkg::GAIN_W-1:0] mdl_gain;
  pdsv_pkg::pdsv_out_t         density_q[$];
  int                          mismatches = 0;
  logic [pdsv_pkg::CRD_W-1:0]  last_px, last_py, last_pz;

  point_density_splat_volume_unit i_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #2 clk = ~clk;

  // Timeout
  initial begin
    #100_000_000;
    $display("tb_top failed");
    $finish;
  end

  // Expected result of one command; updates the model volume on a splat
  function automatic pdsv_pkg::pdsv_out_t predict_density(pdsv_pkg::pdsv_in_t cmd);
    pdsv_pkg::pdsv_out_t r;
    int lo[3], hi[3], c[3];
    longint num, dx, dy, dz, d2, q, s;
    int a;
    r = '0;
    if (cmd.req_type == pdsv_pkg::REQ_READ) begin
      r.read_value = vol_model[(int'(cmd.read_x) * NGY + int'(cmd.read_y)) * NGZ
                               + int'(cmd.read_z)];
      return r;
    end
    c[0] = int'(cmd.point_x);
    c[1] = int'(cmd.point_y);
    c[2] = int'(cmd.point_z);
    for (int n = 0; n < 3; n++) begin
      lo[n] = ((c[n] - int'(mdl_radius)) >>> FB) + 1;
      hi[n] = (c[n] + int'(mdl_radius)) >>> FB;
    end
    num = longint'(mdl_gain) << (2 * FB);
    for (int i = lo[0]; i <= hi[0]; i++)
      for (int j = lo[1]; j <= hi[1]; j++)
        for (int k = lo[2]; k <= hi[2]; k++) begin
          if (i < 0 || i >= NGX || j < 0 || j >= NGY || k < 0 || k >= NGZ) begin
            r.clipped = 1'b1;
            continue;
          end
          dx = c[0] - (i << FB);
          dy = c[1] - (j << FB);
          dz = c[2] - (k << FB);
          d2 = dx * dx + dy * dy + dz * dz;
          if (d2 == 0) q = SAT32;
          else q = num / d2;
          if (q > SAT32 || d2 == 0) begin
            q = SAT32;
            r.saturated = 1'b1;
          end
          a = (i * NGY + j) * NGZ + k;
          s = longint'(vol_model[a]) + q;
          if (s > SAT32) begin
            s = SAT32;
            r.saturated = 1'b1;
          end
          vol_model[a] = s[31:0];
          r.updated_count = r.updated_count + pdsv_pkg::CNT_W'(1);
        end
    return r;
  endfunction

  // Result checker
  always @(posedge clk) begin
    pdsv_pkg::pdsv_out_t want;
    if (rst_n && out_valid) begin
      if (density_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        want = density_q.pop_front();
        if (out_data.read_value !== want.read_value ||
            out_data.updated_count !== want.updated_count ||
            out_data.clipped !== want.clipped ||
            out_data.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected val=%h cnt=%0d clip=%b sat=%b, ",
                      "got val=%h cnt=%0d clip=%b sat=%b"},
                     want.read_value, want.updated_count, want.clipped, want.saturated,
                     out_data.read_value, out_data.updated_count, out_data.clipped,
                     out_data.saturated);
        end
      end
    end
  end

  // Send one command; prediction is taken at the accepting edge
  task automatic send_cmd(pdsv_pkg::pdsv_in_t cmd);
    pdsv_pkg::pdsv_out_t exp_beat;
    @(posedge clk);
    start   <= 1'b1;
    in_data <= cmd;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    start <= 1'b0;
    exp_beat = predict_density(cmd);
    density_q.insert(density_q.size(), exp_beat);
    if (cmd.req_type == pdsv_pkg::REQ_SPLAT) begin
      last_px = cmd.point_x;
      last_py = cmd.point_y;
      last_pz = cmd.point_z;
    end
  endtask

  task automatic idle_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return;
    else if (p < 92) repeat ($urandom_range(1, 3)) @(posedge clk);
    else repeat ($urandom_range(10, 60)) @(posedge clk);
  endtask

  task automatic drain();
    while (density_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [pdsv_pkg::CFG_IDX_W-1:0] idx,
                           logic [pdsv_pkg::CFG_DATA_W-1:0] val);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == pdsv_pkg::REG_RADIUS) mdl_radius = val[pdsv_pkg::RAD_W-1:0];
    else mdl_gain = val;
  endtask

  function automatic pdsv_pkg::pdsv_in_t splat_cmd(int x, int y, int z);
    pdsv_pkg::pdsv_in_t c;
    c = '0;
    c.req_type = pdsv_pkg::REQ_SPLAT;
    c.point_x  = pdsv_pkg::CRD_W'(x);
    c.point_y  = pdsv_pkg::CRD_W'(y);
    c.point_z  = pdsv_pkg::CRD_W'(z);
    return c;
  endfunction

  function automatic pdsv_pkg::pdsv_in_t read_cmd(int x, int y, int z);
    pdsv_pkg::pdsv_in_t c;
    c = '0;
    c.req_type = pdsv_pkg::REQ_READ;
    c.read_x   = pdsv_pkg::RDI_W'(x);
    c.read_y   = pdsv_pkg::RDI_W'(y);
    c.read_z   = pdsv_pkg::RDI_W'(z);
    return c;
  endfunction

  // Directed: corners, clipping, zero distance, empty box, overflow
  task automatic test_directed();
    send_cmd(read_cmd(0, 0, 0));
    send_cmd(read_cmd(31, 31, 31));
    send_cmd(splat_cmd(0, 0, 0));
    send_cmd(splat_cmd(5 * 256, 6 * 256, 7 * 256));
    send_cmd(splat_cmd(8191, 8191, 8191));
    send_cmd(splat_cmd(1300, 2000, 4100));
    send_cmd(read_cmd(5, 6, 7));
    send_cmd(read_cmd(31, 31, 31));
    send_cmd(read_cmd(0, 0, 0));
    write_reg(pdsv_pkg::REG_RADIUS, pdsv_pkg::CFG_DATA_W'(0));
    send_cmd(splat_cmd(3000, 3000, 3000));
    write_reg(pdsv_pkg::REG_RADIUS, pdsv_pkg::CFG_DATA_W'(1023));
    write_reg(pdsv_pkg::REG_GAIN, 24'hFFFFFF);
    send_cmd(splat_cmd(16 * 256, 16 * 256, 16 * 256));
    send_cmd(splat_cmd(16 * 256, 16 * 256, 16 * 256));
    send_cmd(read_cmd(16, 16, 16));
    send_cmd(read_cmd(17, 15, 16));
    send_cmd(splat_cmd(100, 8100, 50));
    write_reg(pdsv_pkg::REG_RADIUS, pdsv_pkg::CFG_DATA_W'(200));
    write_reg(pdsv_pkg::REG_GAIN, pdsv_pkg::CFG_DATA_W'(0));
    send_cmd(splat_cmd(10 * 256 + 128, 20 * 256 + 1, 30 * 256 + 255));
    send_cmd(read_cmd(10, 20, 30));
  endtask

  // Random phase: splats anywhere on the grid and reads, mostly around the last point
  task automatic test_random(int n_items, int max_rad);
    pdsv_pkg::pdsv_in_t c;
    write_reg(pdsv_pkg::REG_RADIUS, pdsv_pkg::CFG_DATA_W'($urandom_range(0, max_rad)));
    write_reg(pdsv_pkg::REG_GAIN, pdsv_pkg::CFG_DATA_W'($urandom_range(0, 99) < 30 ?
                                  $urandom : $urandom_range(0, 500000)));
    for (int n = 0; n < n_items; n++) begin
      idle_gap();
      if ($urandom_range(0, 1)) begin
        c = splat_cmd($urandom_range(0, 8191), $urandom_range(0, 8191),
                      $urandom_range(0, 8191));
        c.read_x = pdsv_pkg::RDI_W'($urandom);
        c.read_y = pdsv_pkg::RDI_W'($urandom);
        c.read_z = pdsv_pkg::RDI_W'($urandom);
        if ($urandom_range(0, 4) == 0) begin
          c.point_x = {5'($urandom_range(0, 31)), 8'd0};
          c.point_y = {5'($urandom_range(0, 31)), 8'd0};
          c.point_z = {5'($urandom_range(0, 31)), 8'd0};
        end
      end else if ($urandom_range(0, 3) != 0) begin
        c = read_cmd(int'(last_px >> FB) + $urandom_range(0, 2) - 1,
                     int'(last_py >> FB) + $urandom_range(0, 2) - 1,
                     int'(last_pz >> FB) + $urandom_range(0, 2) - 1);
        c.point_x = pdsv_pkg::CRD_W'($urandom);
      end else begin
        c = read_cmd($urandom, $urandom, $urandom);
        c.point_y = pdsv_pkg::CRD_W'($urandom);
        c.point_z = pdsv_pkg::CRD_W'($urandom);
      end
      send_cmd(c);
    end
  endtask

  initial begin
    for (int a = 0; a < NGX * NGY * NGZ; a++) vol_model[a] = '0;
    mdl_radius = pdsv_pkg::RADIUS_RST;
    mdl_gain   = pdsv_pkg::GAIN_RST;
    last_px = '0;
    last_py = '0;
    last_pz = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(300, 384);
    test_random(300, 600);
    test_random(8, 1023);
    test_random(300, 300);
    test_random(300, 450);
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && density_q.size() == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule
